### hdl/utf8_to_codepoint_decoder_core_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro checks one implication on the rising edge of i_clk.
`ifndef UTF8_TO_CODEPOINT_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is applied.
`define U8CP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("u8cp same-cycle check failed");

// Next-cycle implication, held off while reset is applied.
`define U8CP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("u8cp next-cycle check failed");

`endif

### hdl/u8cp_pkg.sv
package u8cp_pkg;

    // Error codes carried on the result.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TRUNC    = 2'd1;
    localparam logic [1:0] ERR_BAD_CONT = 2'd2;
    localparam logic [1:0] ERR_BAD_LEAD = 2'd3;

    // Lead byte length patterns, checked against the top bits of the lead.
    localparam logic [2:0] LEAD2_PAT = 3'b110;
    localparam logic [3:0] LEAD3_PAT = 4'b1110;
    localparam logic [4:0] LEAD4_PAT = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    localparam int CP_W = 21;

    // One accepted input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      error_kind;
        logic            string_done;
    } t_result;

    // Result of one decode step: whether a result is produced, and its value.
    typedef struct packed {
        logic    valid;
        t_result result;
    } t_step_out;

endpackage

### hdl/u8cp_in_stage.sv
module u8cp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  u8cp_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output u8cp_pkg::t_in_item o_item
);

    logic               r_valid;
    logic               n_valid;
    u8cp_pkg::t_in_item r_item;
    logic               w_accept;

    // The held item blocks new input only while it cannot move on.
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register loads on every accepted item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/u8cp_decode.sv
module u8cp_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  u8cp_pkg::t_in_item  i_item,
    output u8cp_pkg::t_step_out o_step
);

    logic [1:0]  r_bytes_held;
    logic [1:0]  n_bytes_held;
    logic [7:0]  r_lead;
    logic [7:0]  n_lead;
    logic [11:0] r_partial;
    logic [11:0] n_partial;
    logic        r_discard;
    logic        n_discard;

    logic [7:0]                  w_byte;
    logic                        w_last;
    logic [5:0]                  w_pay;
    logic                        w_cont_ok;
    logic                        w_ok;
    logic                        w_err;
    logic [1:0]                  w_kind;
    logic [u8cp_pkg::CP_W-1:0]   w_cp;

    assign w_byte    = i_item.data_byte;
    assign w_last    = i_item.string_end;
    assign w_pay     = w_byte[5:0];
    assign w_cont_ok = (w_byte[7:6] == u8cp_pkg::CONT_TAG);

    // Decode one byte against the sequence held so far.
    always_comb begin
        n_bytes_held = r_bytes_held;
        n_lead       = r_lead;
        n_partial    = r_partial;
        n_discard    = r_discard;
        w_ok         = 1'b0;
        w_err        = 1'b0;
        w_kind       = u8cp_pkg::ERR_NONE;
        w_cp         = '0;
        if (i_step) begin
            if (r_discard) begin
                // Drop the rest of a failed string up to its final byte.
                if (w_last) begin
                    n_discard = 1'b0;
                end
            end else begin
                case (r_bytes_held)
                    2'd0: begin
                        if (!w_byte[7]) begin
                            w_ok = 1'b1;
                            w_cp = {13'd0, w_byte};
                        end else if (w_last) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_TRUNC;
                        end else begin
                            n_lead       = w_byte;
                            n_bytes_held = 2'd1;
                        end
                    end
                    2'd1: begin
                        if (!w_cont_ok) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_BAD_CONT;
                        end else if (r_lead[7:5] == u8cp_pkg::LEAD2_PAT) begin
                            w_ok = 1'b1;
                            w_cp = {10'd0, r_lead[4:0], w_pay};
                        end else if (w_last) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_TRUNC;
                        end else begin
                            n_partial    = {6'd0, w_pay};
                            n_bytes_held = 2'd2;
                        end
                    end
                    2'd2: begin
                        if (!w_cont_ok) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_BAD_CONT;
                        end else if (r_lead[7:4] == u8cp_pkg::LEAD3_PAT) begin
                            w_ok = 1'b1;
                            w_cp = {5'd0, r_lead[3:0], r_partial[5:0], w_pay};
                        end else if (w_last) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_TRUNC;
                        end else begin
                            n_partial    = {r_partial[5:0], w_pay};
                            n_bytes_held = 2'd3;
                        end
                    end
                    default: begin
                        if (!w_cont_ok) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_BAD_CONT;
                        end else if (r_lead[7:3] != u8cp_pkg::LEAD4_PAT) begin
                            w_err  = 1'b1;
                            w_kind = u8cp_pkg::ERR_BAD_LEAD;
                        end else begin
                            w_ok = 1'b1;
                            w_cp = {r_lead[2:0], r_partial, w_pay};
                        end
                    end
                endcase
                // Any result closes the sequence; an error mid-string starts a drop.
                if (w_ok || w_err) begin
                    n_bytes_held = 2'd0;
                    n_lead       = '0;
                    n_partial    = '0;
                end
                if (w_err) begin
                    n_discard = !w_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_held <= 2'd0;
            r_lead       <= '0;
            r_partial    <= '0;
            r_discard    <= 1'b0;
        end else begin
            r_bytes_held <= n_bytes_held;
            r_lead       <= n_lead;
            r_partial    <= n_partial;
            r_discard    <= n_discard;
        end
    end

    // Error results carry a zero codepoint and always end the string.
    assign o_step.valid              = w_ok || w_err;
    assign o_step.result.code_point  = w_err ? '0 : w_cp;
    assign o_step.result.error_kind  = w_kind;
    assign o_step.result.string_done = w_err || w_last;

endmodule

### hdl/utf8_to_codepoint_decoder_core.sv
// A byte that completes a sequence is held in the input register, decoded, and its result
// is loaded into the result register, which drives the output.
// Throughput: one byte per cycle while the result side does not stall.
// The pace is set by the input register and the result register around one decode step.
// Reset is synchronous and active low; it clears the held sequence and the drop flag.
module utf8_to_codepoint_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_string_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic [1:0]  o_error_kind,
    output logic        o_string_done
);

    u8cp_pkg::t_in_item  w_in_item;
    u8cp_pkg::t_in_item  w_held_item;
    u8cp_pkg::t_step_out w_step;
    logic                w_held_valid;
    logic                w_advance;
    logic                r_out_valid;
    logic                n_out_valid;
    u8cp_pkg::t_result   r_out;

    assign w_in_item.data_byte  = i_data_byte;
    assign w_in_item.string_end = i_string_end;

    // The held item moves on once the result register is free.
    assign w_advance = w_held_valid && (!r_out_valid || !i_out_stall);

    u8cp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .o_stall   (o_in_stall),
        .i_advance (w_advance),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    u8cp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (w_held_item),
        .o_step  (w_step)
    );

    // Result register: loads a new result, or empties when its item is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = w_step.valid;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_step.valid) begin
            r_out <= w_step.result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_out.code_point;
    assign o_error_kind  = r_out.error_kind;
    assign o_string_done = r_out.string_done;

endmodule

### hdl/u8cp_checker.sv
`include "utf8_to_codepoint_decoder_core_assert.svh"

module u8cp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_string_end,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [20:0] o_code_point,
    input logic [1:0]  o_error_kind,
    input logic        o_string_done
);

    logic        w_err_out;
    logic        w_err_form;
    logic [23:0] w_out_fields;

    assign w_err_out    = o_out_valid && (o_error_kind != u8cp_pkg::ERR_NONE);
    assign w_err_form   = (o_code_point == 21'd0) && o_string_done;
    assign w_out_fields = {o_code_point, o_error_kind, o_string_done};

    // An error result carries a zero codepoint and ends its string.
    `U8CP_ASSERT_SAME(a_err_result_form, w_err_out, w_err_form)

    // With the result register empty, the input side never stalls.
    `U8CP_ASSERT_SAME(a_no_stall_when_empty, !o_out_valid, !o_in_stall)

    // A stalled result stays put until it is taken.
    `U8CP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(w_out_fields))

endmodule

bind utf8_to_codepoint_decoder_core u8cp_checker u_u8cp_checker (.*);
